### rtl/core/jacobi_heat_stencil_core_macros.svh
// ---------------------------------------------------------------------------
// jacobi heat stencil core assertion macros
// concurrent checks that compile away when SYNTHESIS is defined
// ---------------------------------------------------------------------------
`ifndef JACOBI_HEAT_STENCIL_CORE_MACROS_SVH
`define JACOBI_HEAT_STENCIL_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define JHS_ASSERT_IMPL(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |-> (cons)) \
        else $error("jhs check failed");
// next-cycle implication
`define JHS_ASSERT_NEXT(label, clk, rst, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst) (ante) |=> (cons)) \
        else $error("jhs check failed");
`else
`define JHS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define JHS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/core/jhs_pkg.sv
// ---------------------------------------------------------------------------
// jhs_pkg
// shared types and codes of the jacobi heat stencil core
// ---------------------------------------------------------------------------
package jhs_pkg;

    localparam int CELL_W  = 32;
    localparam int IDX_IN_W = 6;
    localparam int CFG_CNT_W = 7;
    localparam int ITER_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [1:0] op_t;

    localparam op_t OP_WRITE = 2'd0;
    localparam op_t OP_RUN   = 2'd1;
    localparam op_t OP_READ  = 2'd2;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t REG_ROW_COUNT  = 2'd0;
    localparam cfg_idx_t REG_COL_COUNT  = 2'd1;
    localparam cfg_idx_t REG_ITER_COUNT = 2'd2;

    // sequencer status towards the top level
    typedef struct packed {
        logic busy;
        logic swap;
        logic done;
    } seq_stat_t;

endpackage

### rtl/core/jacobi_heat_stencil_core.sv
// ---------------------------------------------------------------------------
// jacobi_heat_stencil_core
// five-point jacobi heat diffusion over a double-buffered grid
// ---------------------------------------------------------------------------
// usage
//   input channel (in_valid / in_stall) carries one item: opcode, row, col,
//   cell_value. write stores a cell in both buffers, read fetches a cell of
//   the current buffer, run does iteration_count sweeps and swaps buffers
//   once per sweep. every item gives exactly one result item on the output
//   channel (out_valid / out_stall): read_value and status
//   writes and reads take one item per cycle while no run holds the input and
//   the output is not stalled; each result goes through the stage register
//   and then the output register; a run holds the input stalled while it
//   sweeps, since each interior cell needs four fetches through the single
//   read port of the source buffer
//   the configuration port (cfg_we, cfg_index, cfg_data) writes row_count,
//   col_count and iteration_count; write it only while the block is idle
//   reset brings back grid a as current and the default counts; the grid
//   buffers are not cleared, so every cell must be written before use
//   a stalled receiver holds the result in the output register; one more
//   item may enter and wait in the stage before it, then the input stalls
// ---------------------------------------------------------------------------
`include "jacobi_heat_stencil_core_macros.svh"

module jacobi_heat_stencil_core #(
    parameter int GRID_MAX = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // input item channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  jhs_pkg::op_t                        opcode,
    input  logic [jhs_pkg::IDX_IN_W-1:0]        row,
    input  logic [jhs_pkg::IDX_IN_W-1:0]        col,
    input  logic [jhs_pkg::CELL_W-1:0]          cell_value,
    // result item channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [jhs_pkg::CELL_W-1:0]          read_value,
    output logic                                status,
    // configuration writes
    input  logic                                cfg_we,
    input  jhs_pkg::cfg_idx_t                   cfg_index,
    input  logic [jhs_pkg::CFG_W-1:0]           cfg_data
);

    import jhs_pkg::*;

    localparam int IDX_W  = $clog2(GRID_MAX);
    localparam int CNT_W  = $clog2(GRID_MAX + 1);
    localparam int ADDR_W = 2 * IDX_W;

    // configuration registers
    logic [CFG_CNT_W-1:0] row_count_reg;
    logic [CFG_CNT_W-1:0] col_count_reg;
    logic [ITER_W-1:0]    iter_count_reg;

    // buffer select, set when grid b holds the current state
    logic current_is_b_reg;

    // stage between accept and the output register (read data arrives here)
    logic s1_valid_reg, s1_valid_next;
    logic s1_is_read_reg, s1_is_read_next;
    logic s1_src_b_reg, s1_src_b_next;
    logic s1_status_reg, s1_status_next;
    logic s1_adv;

    // output register
    logic              out_valid_reg;
    logic [CELL_W-1:0] read_value_reg;
    logic              status_reg;
    logic [CELL_W-1:0] s1_value;

    // item decode
    logic              item_accept;
    logic              in_range;
    logic [ADDR_W-1:0] item_addr;
    logic              item_write_hit;
    logic              item_read_hit;
    logic [CNT_W-1:0]  rows_eff;
    logic [CNT_W-1:0]  cols_eff;
    logic              grid_small;
    logic              run_start;

    // memory ports
    logic              we_a, we_b, re_a, re_b;
    logic [ADDR_W-1:0] waddr, raddr;
    logic [CELL_W-1:0] wdata;
    logic [CELL_W-1:0] rdata_a, rdata_b, rdata_src;

    // sweep sequencer
    logic              seq_rd_en, seq_wr_en;
    logic [ADDR_W-1:0] seq_rd_addr, seq_wr_addr;
    logic [CELL_W-1:0] seq_wr_data;
    seq_stat_t         seq_stat;

    assign item_accept = in_valid && !in_stall;
    assign in_range    = (32'(row) < GRID_MAX) && (32'(col) < GRID_MAX);
    assign item_addr   = {IDX_W'(row), IDX_W'(col)};

    assign item_write_hit = item_accept && (opcode == OP_WRITE) && in_range;
    assign item_read_hit  = item_accept && (opcode == OP_READ) && in_range;

    // counts above the grid size saturate
    assign rows_eff = (32'(row_count_reg) > GRID_MAX) ? CNT_W'(GRID_MAX)
                                                      : CNT_W'(row_count_reg);
    assign cols_eff = (32'(col_count_reg) > GRID_MAX) ? CNT_W'(GRID_MAX)
                                                      : CNT_W'(col_count_reg);
    assign grid_small = (rows_eff < CNT_W'(2)) || (cols_eff < CNT_W'(2));
    assign run_start  = item_accept && (opcode == OP_RUN) && !grid_small;

    // no new item during a run, nor when both result slots are full
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = seq_stat.busy || (s1_valid_reg && out_valid_reg && out_stall);

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg  <= CFG_CNT_W'(64);
            col_count_reg  <= CFG_CNT_W'(64);
            iter_count_reg <= ITER_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW_COUNT:  row_count_reg  <= cfg_data[CFG_CNT_W-1:0];
                REG_COL_COUNT:  col_count_reg  <= cfg_data[CFG_CNT_W-1:0];
                REG_ITER_COUNT: iter_count_reg <= cfg_data[ITER_W-1:0];
                default:        ;
            endcase
        end
    end

    // result stage
    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        s1_is_read_next = s1_is_read_reg;
        s1_src_b_next   = s1_src_b_reg;
        s1_status_next  = s1_status_reg;
        if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        if (item_accept && !run_start)
        begin
            // writes, reads, unused codes and a run on a too-small grid
            s1_valid_next   = 1'b1;
            s1_is_read_next = item_read_hit;
            s1_src_b_next   = current_is_b_reg;
            s1_status_next  = (opcode == OP_RUN);
        end
        else if (seq_stat.done)
        begin
            s1_valid_next   = 1'b1;
            s1_is_read_next = 1'b0;
            s1_src_b_next   = current_is_b_reg;
            s1_status_next  = 1'b0;
        end
    end

    assign s1_value = s1_is_read_reg ? (s1_src_b_reg ? rdata_b : rdata_a) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_is_b_reg <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s1_is_read_reg   <= 1'b0;
            s1_src_b_reg     <= 1'b0;
            s1_status_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (seq_stat.swap)
            begin
                current_is_b_reg <= !current_is_b_reg;
            end
            s1_valid_reg   <= s1_valid_next;
            s1_is_read_reg <= s1_is_read_next;
            s1_src_b_reg   <= s1_src_b_next;
            s1_status_reg  <= s1_status_next;
            out_valid_reg  <= s1_adv || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            read_value_reg <= s1_value;
            status_reg     <= s1_status_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;

    // buffer ports: item accesses and the sweep never share a cycle
    assign waddr = seq_wr_en ? seq_wr_addr : item_addr;
    assign wdata = seq_wr_en ? seq_wr_data : cell_value;
    assign raddr = seq_rd_en ? seq_rd_addr : item_addr;

    assign we_a = item_write_hit || (seq_wr_en && current_is_b_reg);
    assign we_b = item_write_hit || (seq_wr_en && !current_is_b_reg);
    assign re_a = (item_read_hit || seq_rd_en) && !current_is_b_reg;
    assign re_b = (item_read_hit || seq_rd_en) && current_is_b_reg;

    assign rdata_src = current_is_b_reg ? rdata_b : rdata_a;

    jhs_grid_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (CELL_W)
    ) u_grid_a (
        .clk   (clk),
        .we    (we_a),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re_a),
        .raddr (raddr),
        .rdata (rdata_a)
    );

    jhs_grid_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (CELL_W)
    ) u_grid_b (
        .clk   (clk),
        .we    (we_b),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re_b),
        .raddr (raddr),
        .rdata (rdata_b)
    );

    jhs_sweep_seq #(
        .GRID_MAX (GRID_MAX)
    ) u_sweep_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (run_start),
        .rows    (rows_eff),
        .cols    (cols_eff),
        .iters   (iter_count_reg),
        .rd_data (rdata_src),
        .rd_en   (seq_rd_en),
        .rd_addr (seq_rd_addr),
        .wr_en   (seq_wr_en),
        .wr_addr (seq_wr_addr),
        .wr_data (seq_wr_data),
        .stat    (seq_stat)
    );

    `JHS_ASSERT_IMPL(a_run_stage_empty, clk, rst_n, seq_stat.busy, !s1_valid_reg)
    `JHS_ASSERT_NEXT(a_done_gives_result, clk, rst_n, seq_stat.done,
        s1_valid_reg && !s1_status_reg && !s1_is_read_reg)
    `JHS_ASSERT_NEXT(a_read_lands_in_stage, clk, rst_n, item_read_hit,
        s1_valid_reg && s1_is_read_reg && (s1_src_b_reg == current_is_b_reg))

endmodule

### rtl/core/jhs_grid_mem.sv
// ---------------------------------------------------------------------------
// jhs_grid_mem
// one grid buffer: single write port, single read port, registered read data
// ---------------------------------------------------------------------------
module jhs_grid_mem #(
    parameter int ADDR_W = 12,
    parameter int DATA_W = 32
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/jhs_sweep_seq.sv
// ---------------------------------------------------------------------------
// jhs_sweep_seq
// walks the interior cells, fetches four neighbours and writes their mean
// ---------------------------------------------------------------------------
`include "jacobi_heat_stencil_core_macros.svh"

module jhs_sweep_seq #(
    parameter int GRID_MAX = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [$clog2(GRID_MAX+1)-1:0]       rows,
    input  logic [$clog2(GRID_MAX+1)-1:0]       cols,
    input  logic [jhs_pkg::ITER_W-1:0]          iters,
    input  logic [jhs_pkg::CELL_W-1:0]          rd_data,
    output logic                                rd_en,
    output logic [2*$clog2(GRID_MAX)-1:0]       rd_addr,
    output logic                                wr_en,
    output logic [2*$clog2(GRID_MAX)-1:0]       wr_addr,
    output logic [jhs_pkg::CELL_W-1:0]          wr_data,
    output jhs_pkg::seq_stat_t                  stat
);

    import jhs_pkg::*;

    localparam int IDX_W  = $clog2(GRID_MAX);
    localparam int CNT_W  = $clog2(GRID_MAX + 1);
    localparam int ADDR_W = 2 * IDX_W;
    localparam int ACC_W  = CELL_W + 2;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    localparam logic [1:0] PH_NORTH = 2'd0;
    localparam logic [1:0] PH_SOUTH = 2'd1;
    localparam logic [1:0] PH_WEST  = 2'd2;
    localparam logic [1:0] PH_EAST  = 2'd3;

    localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);

    logic [1:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [ITER_W-1:0] iter_left_reg, iter_left_next;
    logic              empty_reg, empty_next;
    logic              vld_d_reg;
    logic [1:0]        phase_d_reg;
    logic [IDX_W-1:0]  last_i_reg, last_i_next;
    logic [IDX_W-1:0]  last_j_reg, last_j_next;
    logic [ADDR_W-1:0] cell_d_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  sum;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        iter_left_next = iter_left_reg;
        empty_next     = empty_reg;
        last_i_next    = last_i_reg;
        last_j_next    = last_j_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    i_next         = IDX_ONE;
                    j_next         = IDX_ONE;
                    phase_next     = PH_NORTH;
                    iter_left_next = iters;
                    empty_next     = (rows < CNT_W'(3)) || (cols < CNT_W'(3));
                    last_i_next    = IDX_W'(rows - CNT_W'(2));
                    last_j_next    = IDX_W'(cols - CNT_W'(2));
                    if (iters == '0)
                    begin
                        state_next = S_DONE;
                    end
                    else if (empty_next)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                phase_next = phase_reg + 2'd1;
                if (phase_reg == PH_EAST)
                begin
                    if (j_reg == last_j_reg)
                    begin
                        j_next = IDX_ONE;
                        if (i_reg == last_i_reg)
                        begin
                            i_next     = IDX_ONE;
                            state_next = S_DRAIN;
                        end
                        else
                        begin
                            i_next = i_reg + IDX_ONE;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + IDX_ONE;
                    end
                end
            end
            S_DRAIN:
            begin
                // last mean is written here, buffers swap at the edge
                iter_left_next = iter_left_reg - ITER_W'(1);
                if (iter_left_reg == ITER_W'(1))
                begin
                    state_next = S_DONE;
                end
                else if (empty_reg)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_NORTH;
            i_reg         <= IDX_ONE;
            j_reg         <= IDX_ONE;
            iter_left_reg <= '0;
            empty_reg     <= 1'b0;
            vld_d_reg     <= 1'b0;
            phase_d_reg   <= PH_NORTH;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            iter_left_reg <= iter_left_next;
            empty_reg     <= empty_next;
            vld_d_reg     <= rd_en;
            phase_d_reg   <= phase_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        last_i_reg <= last_i_next;
        last_j_reg <= last_j_next;
        if (rd_en)
        begin
            cell_d_reg <= {i_reg, j_reg};
        end
        if (vld_d_reg)
        begin
            acc_reg <= sum;
        end
    end

    // neighbour address for this phase
    always_comb
    begin
        rd_en = (state_reg == S_READ);
        case (phase_reg)
            PH_NORTH: rd_addr = {i_reg - IDX_ONE, j_reg};
            PH_SOUTH: rd_addr = {i_reg + IDX_ONE, j_reg};
            PH_WEST:  rd_addr = {i_reg, j_reg - IDX_ONE};
            PH_EAST:  rd_addr = {i_reg, j_reg + IDX_ONE};
            default:  rd_addr = {i_reg, j_reg};
        endcase
    end

    assign sum     = ((phase_d_reg == PH_NORTH) ? '0 : acc_reg) + {2'b00, rd_data};
    assign wr_en   = vld_d_reg && (phase_d_reg == PH_EAST);
    assign wr_addr = cell_d_reg;
    assign wr_data = sum[ACC_W-1:2];

    assign stat.busy = (state_reg != S_IDLE);
    assign stat.swap = (state_reg == S_DRAIN);
    assign stat.done = (state_reg == S_DONE);

    `JHS_ASSERT_IMPL(a_wr_interior, clk, rst_n, wr_en,
        (wr_addr[ADDR_W-1:IDX_W] != '0) && (wr_addr[IDX_W-1:0] != '0))
    `JHS_ASSERT_NEXT(a_drain_empty_pipe, clk, rst_n, state_reg == S_DRAIN, !vld_d_reg)
    `JHS_ASSERT_NEXT(a_done_to_idle, clk, rst_n, stat.done, !stat.busy && !wr_en)

endmodule

### tb/tb_jacobi_heat_stencil_core.sv
// ---------------------------------------------------------------------------
// tb_jacobi_heat_stencil_core
// self-checking bench for the double-buffered jacobi heat stencil: a short
// table of hand-checked items, then random phases that fill the active grid,
// mix writes, reads, sweeps and spare opcodes, and compare every result item
// with a cycle-free model of the grid kept in the bench
// ---------------------------------------------------------------------------
module tb_jacobi_heat_stencil_core;

    timeunit 1ns;
    timeprecision 1ps;

    import jhs_pkg::*;

    localparam int          GRID         = 64;
    localparam int          CELLS        = GRID * GRID;
    localparam realtime     CLK_PERIOD   = 12ns;
    localparam int          RANDOM_ITEMS = 550;
    localparam int          MIN_PHASES   = 10;
    localparam longint      LIMIT_CYCLES = 1_500_000;

    // opcode with no function, answered with zeros
    localparam op_t OP_SPARE = 2'd3;

    typedef struct packed {
        logic [CELL_W-1:0] read_value;
        logic              status;
    } answer_t;

    // one row of the hand-written table: a register write or an item
    typedef struct packed {
        logic                  is_reg;
        cfg_idx_t              idx;
        logic [CFG_W-1:0]      data;
        op_t                   op;
        logic [IDX_IN_W-1:0]   r;
        logic [IDX_IN_W-1:0]   c;
        logic [CELL_W-1:0]     v;
        logic                  typed;
        answer_t               want;
    } plan_step_t;

    // every input is known from time zero
    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  in_valid   = 1'b0;
    logic                  in_stall;
    op_t                   opcode     = OP_WRITE;
    logic [IDX_IN_W-1:0]   row        = '0;
    logic [IDX_IN_W-1:0]   col        = '0;
    logic [CELL_W-1:0]     cell_value = '0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [CELL_W-1:0]     read_value;
    logic                  status;
    logic                  cfg_we     = 1'b0;
    cfg_idx_t              cfg_index  = REG_ROW_COUNT;
    logic [CFG_W-1:0]      cfg_data   = '0;

    // bench copy of the grid: both buffers, the current one, the counts
    logic [CELL_W-1:0]     heat [0:1][0:CELLS-1];
    bit                    b_current  = 1'b0;
    logic [CFG_CNT_W-1:0]  rows_cfg   = 7'd64;
    logic [CFG_CNT_W-1:0]  cols_cfg   = 7'd64;
    logic [ITER_W-1:0]     sweeps_cfg = 16'd1;

    // cells that have held a written value, so no read ever sees garbage
    bit                    cell_set [0:CELLS-1];

    answer_t               answers_due [$];
    int unsigned           fault_count = 0;
    int unsigned           items_sent  = 0;

    // sender burst state
    int                    burst_left  = 0;
    int                    gap_left    = 0;
    bit                    valid_held  = 1'b0;

    // receiver stall pattern state
    int                    mode_left   = 0;
    int                    stall_mode  = 0;

    jacobi_heat_stencil_core #(
        .GRID_MAX   (GRID)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .row        (row),
        .col        (col),
        .cell_value (cell_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .status     (status),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // one jacobi sweep from the current buffer into the other one
    // sum kept at 34 bits so four full-scale cells cannot wrap
    function automatic void relax_grid(int unsigned nr, int unsigned nc);
        logic [CELL_W+1:0] acc;
        int                k;
        for (int i = 1; i + 1 < nr; i++) begin
            for (int j = 1; j + 1 < nc; j++) begin
                k   = i * GRID + j;
                acc = 34'(heat[b_current][k - GRID]) + 34'(heat[b_current][k + GRID])
                    + 34'(heat[b_current][k - 1])    + 34'(heat[b_current][k + 1]);
                heat[!b_current][k] = acc[CELL_W+1:2];
            end
        end
    endfunction

    // answer to one accepted item, updating the bench grid as the block would
    function automatic answer_t model_item(op_t op, logic [IDX_IN_W-1:0] r,
                                          logic [IDX_IN_W-1:0] c, logic [CELL_W-1:0] v);
        answer_t     ans;
        int unsigned nr;
        int unsigned nc;
        int          k;
        ans = '0;
        k   = int'(r) * GRID + int'(c);
        case (op)
            OP_WRITE: begin
                heat[0][k]  = v;
                heat[1][k]  = v;
                cell_set[k] = 1'b1;
            end
            OP_RUN: begin
                // counts above the grid size saturate
                nr = (rows_cfg > GRID) ? GRID : int'(rows_cfg);
                nc = (cols_cfg > GRID) ? GRID : int'(cols_cfg);
                if (nr < 2 || nc < 2) begin
                    ans.status = 1'b1;
                end else begin
                    for (int n = 0; n < int'(sweeps_cfg); n++) begin
                        relax_grid(nr, nc);
                        b_current = !b_current;
                    end
                end
            end
            OP_READ: ans.read_value = heat[b_current][k];
            default: ;
        endcase
        return ans;
    endfunction

    // temperatures biased towards the extremes so the sum carries reach bit 33
    function automatic logic [CELL_W-1:0] pick_temp();
        case ($urandom_range(0, 3))
            0:       return 32'hFFFF_FFFF - $urandom_range(0, 255);
            1:       return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    function automatic plan_step_t reg_step(cfg_idx_t idx, logic [CFG_W-1:0] data);
        plan_step_t s;
        s        = '0;
        s.is_reg = 1'b1;
        s.idx    = idx;
        s.data   = data;
        return s;
    endfunction

    function automatic plan_step_t item_step(op_t op, int r, int c, logic [CELL_W-1:0] v,
                                             bit typed, logic [CELL_W-1:0] rv, logic st);
        plan_step_t s;
        s                 = '0;
        s.op              = op;
        s.r               = IDX_IN_W'(r);
        s.c               = IDX_IN_W'(c);
        s.v               = v;
        s.typed           = typed;
        s.want.read_value = rv;
        s.want.status     = st;
        return s;
    endfunction

    // present one item, hold it until taken, then book its expected answer
    // the burst bookkeeping decides here whether valid drops for a gap
    task automatic offer_item(op_t op, logic [IDX_IN_W-1:0] r, logic [IDX_IN_W-1:0] c,
                              logic [CELL_W-1:0] v, bit typed, answer_t want);
        answer_t ans;
        while (gap_left > 0)
        begin
            @(posedge clk);
            gap_left--;
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        row        <= r;
        col        <= c;
        cell_value <= v;
        valid_held = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        ans = model_item(op, r, c, v);
        answers_due.push_back(typed ? want : ans);
        items_sent++;
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 24);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap_left > 0)
            begin
                in_valid   <= 1'b0;
                valid_held = 1'b0;
            end
        end
    endtask

    // drop valid and let every outstanding item come back before touching registers
    task automatic settle();
        if (valid_held)
        begin
            in_valid   <= 1'b0;
            valid_held = 1'b0;
        end
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // one register write, mirrored into the bench copy
    task automatic set_reg(cfg_idx_t idx, logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ROW_COUNT:  rows_cfg   = data[CFG_CNT_W-1:0];
            REG_COL_COUNT:  cols_cfg   = data[CFG_CNT_W-1:0];
            REG_ITER_COUNT: sweeps_cfg = data[ITER_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // receiver: stretches of free flow, light stalling and heavy stalling
    always @(posedge clk)
    begin
        if (mode_left == 0)
        begin
            stall_mode <= $urandom_range(0, 2);
            mode_left  <= $urandom_range(16, 160);
            out_stall  <= 1'b0;
        end
        else
        begin
            mode_left <= mode_left - 1;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    // result checker: every taken result against the oldest expectation
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (answers_due.size() == 0)
            begin
                $error("result item with nothing expected: read_value %h status %b",
                       read_value, status);
                fault_count++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (read_value !== want.read_value)
                begin
                    $error("read_value: expected %h, got %h", want.read_value, read_value);
                    fault_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %b, got %b", want.status, status);
                    fault_count++;
                end
            end
        end
    end

    // hard stop in case the block hangs
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        plan_step_t          plan [$];
        int                  phase_no;
        int unsigned         random_from;
        int                  nr;
        int                  nc;
        int                  nit;
        int                  er;
        int                  ec;
        int                  sel;
        int                  k;
        logic [IDX_IN_W-1:0] r;
        logic [IDX_IN_W-1:0] c;

        // directed part
        // corner cells at both ends of the index range, full-scale values,
        // the spare opcode, every flavour of too-small grid, a 3x3 grid whose
        // neighbours all sit at full scale, zero sweeps, and a 2-row grid with
        // the largest sweep count, where only the buffer swap happens
        plan = '{
            item_step(OP_WRITE,  0,  0, 32'h0000_0000, 1, 32'h0, 1'b0),
            item_step(OP_WRITE, 63, 63, 32'hFFFF_FFFF, 1, 32'h0, 1'b0),
            item_step(OP_READ,  63, 63, 32'h0000_0000, 1, 32'hFFFF_FFFF, 1'b0),
            item_step(OP_READ,   0,  0, 32'hFFFF_FFFF, 1, 32'h0, 1'b0),
            item_step(OP_SPARE, 63, 63, 32'hFFFF_FFFF, 1, 32'h0, 1'b0),
            reg_step(REG_ROW_COUNT, 16'd0),
            item_step(OP_RUN,    0,  0, 32'h0, 1, 32'h0, 1'b1),
            reg_step(REG_ROW_COUNT, 16'd1),
            item_step(OP_RUN,    0,  0, 32'h0, 1, 32'h0, 1'b1),
            reg_step(REG_ROW_COUNT, 16'd3),
            reg_step(REG_COL_COUNT, 16'd1),
            item_step(OP_RUN,    0,  0, 32'h0, 1, 32'h0, 1'b1),
            reg_step(REG_COL_COUNT, 16'd3),
            item_step(OP_WRITE,  0,  1, 32'hFFFF_FFFF, 1, 32'h0, 1'b0),
            item_step(OP_WRITE,  1,  0, 32'hFFFF_FFFF, 1, 32'h0, 1'b0),
            item_step(OP_WRITE,  1,  2, 32'hFFFF_FFFF, 1, 32'h0, 1'b0),
            item_step(OP_WRITE,  2,  1, 32'hFFFF_FFFF, 1, 32'h0, 1'b0),
            item_step(OP_WRITE,  1,  1, 32'h0000_0000, 1, 32'h0, 1'b0),
            reg_step(REG_ITER_COUNT, 16'd0),
            item_step(OP_RUN,    0,  0, 32'h0, 1, 32'h0, 1'b0),
            item_step(OP_READ,   1,  1, 32'h0, 1, 32'h0, 1'b0),
            reg_step(REG_ITER_COUNT, 16'd1),
            item_step(OP_RUN,    0,  0, 32'h0, 1, 32'h0, 1'b0),
            item_step(OP_READ,   1,  1, 32'h0, 1, 32'hFFFF_FFFF, 1'b0),
            item_step(OP_READ,   1,  2, 32'h0, 0, 32'h0, 1'b0),
            reg_step(REG_ROW_COUNT, 16'd2),
            reg_step(REG_ITER_COUNT, 16'hFFFF),
            item_step(OP_RUN,    0,  0, 32'h0, 1, 32'h0, 1'b0),
            item_step(OP_READ,   1,  1, 32'h0, 1, 32'h0, 1'b0)
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_reg)
            begin
                settle();
                set_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                offer_item(plan[i].op, plan[i].r, plan[i].c, plan[i].v,
                           plan[i].typed, plan[i].want);
            end
        end

        // random part, one grid setting per phase
        // the first four reach the largest row and column counts and the
        // saturating ones; later phases keep the grid small so sweeps stay short
        phase_no    = 0;
        random_from = items_sent;
        while (phase_no < MIN_PHASES || items_sent - random_from < RANDOM_ITEMS)
        begin
            case (phase_no)
                0:
                begin
                    nr  = GRID;
                    nc  = 3;
                    nit = $urandom_range(1, 2);
                end
                1:
                begin
                    nr  = 3;
                    nc  = GRID;
                    nit = $urandom_range(1, 2);
                end
                2:
                begin
                    nr  = $urandom_range(GRID + 1, 127);
                    nc  = 2;
                    nit = $urandom_range(1, 2000);
                end
                3:
                begin
                    nr  = 2;
                    nc  = $urandom_range(GRID + 1, 127);
                    nit = $urandom_range(1, 2000);
                end
                default:
                begin
                    nr  = $urandom_range(2, 9);
                    nc  = $urandom_range(2, 9);
                    nit = $urandom_range(0, 4);
                    // now and then a grid too small to sweep
                    if ($urandom_range(0, 5) == 0)
                    begin
                        if ($urandom_range(0, 1) == 1)
                            nr = $urandom_range(0, 1);
                        else
                            nc = $urandom_range(0, 1);
                    end
                end
            endcase

            // bits above the 7-bit counts carry junk the block must drop
            settle();
            set_reg(REG_ROW_COUNT, CFG_W'(($urandom_range(0, 511) << 7) | nr));
            set_reg(REG_COL_COUNT, CFG_W'(($urandom_range(0, 511) << 7) | nc));
            set_reg(REG_ITER_COUNT, CFG_W'(nit));

            // fill whatever of the active region has never been written
            er = (nr > GRID) ? GRID : nr;
            ec = (nc > GRID) ? GRID : nc;
            for (int i = 0; i < er; i++)
            begin
                for (int j = 0; j < ec; j++)
                begin
                    if (!cell_set[i * GRID + j])
                        offer_item(OP_WRITE, IDX_IN_W'(i), IDX_IN_W'(j), pick_temp(),
                                   1'b0, '0);
                end
            end

            // random mix; reads only ever touch cells that hold a written value
            repeat ((phase_no < 4) ? 12 : 24)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 45)
                begin
                    if (er > 0 && ec > 0 && $urandom_range(0, 9) < 7)
                    begin
                        r = IDX_IN_W'($urandom_range(0, er - 1));
                        c = IDX_IN_W'($urandom_range(0, ec - 1));
                    end
                    else
                    begin
                        r = IDX_IN_W'($urandom);
                        c = IDX_IN_W'($urandom);
                    end
                    offer_item(OP_WRITE, r, c, pick_temp(), 1'b0, '0);
                end
                else if (sel < 75)
                begin
                    if (er > 0 && ec > 0 && $urandom_range(0, 9) < 6)
                    begin
                        r = IDX_IN_W'($urandom_range(0, er - 1));
                        c = IDX_IN_W'($urandom_range(0, ec - 1));
                    end
                    else
                    begin
                        do
                            k = $urandom_range(0, CELLS - 1);
                        while (!cell_set[k]);
                        r = IDX_IN_W'(k / GRID);
                        c = IDX_IN_W'(k % GRID);
                    end
                    offer_item(OP_READ, r, c, $urandom, 1'b0, '0);
                end
                else if (sel < 90)
                begin
                    // region is fully written by now, so a run is always legal
                    offer_item(OP_RUN, IDX_IN_W'($urandom), IDX_IN_W'($urandom), $urandom,
                               1'b0, '0);
                end
                else
                begin
                    offer_item(OP_SPARE, IDX_IN_W'($urandom), IDX_IN_W'($urandom), $urandom,
                               1'b0, '0);
                end
            end
            phase_no++;
        end

        // drain, then a short tail to catch any stray result item
        settle();
        repeat (20) @(posedge clk);

        if (fault_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/jhs_pkg.sv
rtl/core/jhs_grid_mem.sv
rtl/core/jhs_sweep_seq.sv
rtl/core/jacobi_heat_stencil_core.sv
tb/tb_jacobi_heat_stencil_core.sv
